// ===== src/assert_macros.svh =====
// assertion macros shared by the table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold on every clock edge out of reset
`define SWFT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// consequent must hold in the cycle after the antecedent
`define SWFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== src/swft_pkg.sv =====
// types, constants and helpers of the sorted word frequency table
package swft_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int KEY_BITS    = 120;
   localparam int KEY_BYTES   = 15;
   localparam int COUNT_BITS  = 32;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [2:0] ST_COUNTED    = 3'd0;
   localparam logic [2:0] ST_INSERTED   = 3'd1;
   localparam logic [2:0] ST_DROPPED    = 3'd2;
   localparam logic [2:0] ST_READ_OK    = 3'd3;
   localparam logic [2:0] ST_RANK_EMPTY = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_UPD
   } state_type;

   typedef struct packed {
      logic        command;
      logic [63:0] key_hi;
      logic [55:0] key_lo;
      logic [7:0]  rank;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] word_hi;
      logic [55:0] word_lo;
      logic [31:0] word_count;
      logic [7:0]  position;
      logic [8:0]  distinct_words;
   } rsp_payload_type;

   // control from the sequencer to every cell
   typedef struct packed {
      logic capture;
      logic bump;
      logic insert;
   } cell_ctrl_type;

   // what a cell shows its right-hand neighbor
   typedef struct packed {
      logic                  valid;
      logic                  lt;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] count;
   } cell_view_type;

   // per-cell match flags seen by the result collector
   typedef struct packed {
      logic eq;
      logic hit;
      logic boundary;
   } cell_flag_type;

   // clear every byte after the first zero byte, string style
   function automatic logic [KEY_BITS-1:0] canon_key(input logic [KEY_BITS-1:0] raw);
      logic [KEY_BITS-1:0] res;
      logic                alive;
      res   = raw;
      alive = 1'b1;
      for (int b = 0; b < KEY_BYTES; b++) begin
         if (!alive) begin
            res[KEY_BITS-1-8*b -: 8] = 8'h00;
         end else if (raw[KEY_BITS-1-8*b -: 8] == 8'h00) begin
            alive = 1'b0;
         end
      end
      return res;
   endfunction

endpackage

// ===== src/swft_chan_if.sv =====
// valid/ready channel carrying one payload word
interface swft_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/sorted_word_frequency_table_core.sv =====
// top level of the sorted word frequency table: sequencer, cell chain, result register
//
//   channel   dir  handshake            payload
//   req_chan  in   valid/ready          command, key_hi, key_lo, rank
//   rsp_chan  out  valid/ready          status, word_hi, word_lo, word_count,
//                                       position, distinct_words
//
// each word passes through three steps: accept, compare in every cell, update the chain
// the update waits while the result register still holds an untaken word
// a new word is accepted while a finished result waits downstream
// reset (synchronous, active high) empties the chain by clearing the valid bits
// cell contents hold no reset; an empty cell is never read out
`include "assert_macros.svh"

module sorted_word_frequency_table_core #(
   parameter int TABLE_DEPTH = swft_pkg::TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   swft_chan_if.sink         req_chan,
   swft_chan_if.source       rsp_chan
);

   localparam int TW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);

   // sequencer state
   swft_pkg::state_type                 state_ff;
   swft_pkg::state_type                 state_in;

   // held request, key already canonical
   logic                                cmd_ff;
   logic [swft_pkg::KEY_BITS-1:0]       key_ff;
   logic [7:0]                          rank_ff;

   // number of words held
   logic [TW-1:0]                       total_ff;
   logic [TW-1:0]                       total_in;

   // result register
   logic                                rsp_valid_ff;
   swft_pkg::rsp_payload_type           rsp_data_ff;
   swft_pkg::rsp_payload_type           rsp_data_in;

   swft_pkg::cell_ctrl_type             ctrl;
   swft_pkg::cell_view_type             view [TABLE_DEPTH];
   swft_pkg::cell_flag_type             flag [TABLE_DEPTH];
   swft_pkg::cell_view_type             head_view;

   logic                                accept;
   logic                                slot_free;
   logic                                upd_fire;
   logic                                full;

   // result bus gathered from the chain
   logic                                found;
   logic                                any_hit;
   logic [swft_pkg::KEY_BITS-1:0]       rd_key;
   logic [swft_pkg::COUNT_BITS-1:0]     rd_count;
   logic [swft_pkg::COUNT_BITS-1:0]     eq_count;
   logic [swft_pkg::COUNT_BITS-1:0]     eq_count_next;
   logic [IW-1:0]                       bnd_idx;

   // checker views
   logic [TABLE_DEPTH-1:0]              valid_vec;
   logic [TABLE_DEPTH-1:0]              bnd_vec;

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign upd_fire  = (state_ff == swft_pkg::S_UPD) && slot_free;
   assign full      = (total_ff == TW'(TABLE_DEPTH));

   assign req_chan.ready   = (state_ff == swft_pkg::S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // the chain head sees a virtual left neighbor that is below every key
   assign head_view.valid = 1'b0;
   assign head_view.lt    = 1'b1;
   assign head_view.key   = '0;
   assign head_view.count = '0;

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
         swft_cell #(
            .CELL_INDEX (gi)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .req_key  (key_ff),
            .req_rank (rank_ff),
            .prev     ((gi == 0) ? head_view : view[(gi == 0) ? 0 : gi - 1]),
            .view     (view[gi]),
            .flag     (flag[gi])
         );
         assign valid_vec[gi] = view[gi].valid;
         assign bnd_vec[gi]   = flag[gi].boundary;
      end
   endgenerate

   // one-hot or-bus over the chain
   always_comb begin
      found    = 1'b0;
      any_hit  = 1'b0;
      rd_key   = '0;
      rd_count = '0;
      eq_count = '0;
      bnd_idx  = '0;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         found   = found | flag[j].eq;
         any_hit = any_hit | flag[j].hit;
         if (flag[j].hit) begin
            rd_key   = rd_key | view[j].key;
            rd_count = rd_count | view[j].count;
         end
         if (flag[j].eq) begin
            eq_count = eq_count | view[j].count;
         end
         if (flag[j].boundary) begin
            bnd_idx = bnd_idx | IW'(j);
         end
      end
   end

   // saturating count as it stands after the bump
   assign eq_count_next = (eq_count == '1) ? eq_count : eq_count + 1'b1;

   // sequencer: next state, cell control, result assembly
   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      ctrl        = '0;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         swft_pkg::S_IDLE: begin
            if (accept) begin
               state_in = swft_pkg::S_CMP;
            end
         end
         swft_pkg::S_CMP: begin
            ctrl.capture = 1'b1;
            state_in     = swft_pkg::S_UPD;
         end
         swft_pkg::S_UPD: begin
            if (slot_free) begin
               state_in = swft_pkg::S_IDLE;
               rsp_data_in.word_hi    = '0;
               rsp_data_in.word_lo    = '0;
               rsp_data_in.word_count = '0;
               rsp_data_in.position   = '0;
               if (cmd_ff == swft_pkg::CMD_READ) begin
                  rsp_data_in.position = rank_ff;
                  if (any_hit) begin
                     rsp_data_in.status     = swft_pkg::ST_READ_OK;
                     rsp_data_in.word_hi    = rd_key[119:56];
                     rsp_data_in.word_lo    = rd_key[55:0];
                     rsp_data_in.word_count = rd_count;
                  end else begin
                     rsp_data_in.status = swft_pkg::ST_RANK_EMPTY;
                  end
               end else begin
                  rsp_data_in.word_hi = key_ff[119:56];
                  rsp_data_in.word_lo = key_ff[55:0];
                  if (found) begin
                     ctrl.bump              = 1'b1;
                     rsp_data_in.status     = swft_pkg::ST_COUNTED;
                     rsp_data_in.word_count = eq_count_next;
                     rsp_data_in.position   = 8'(bnd_idx);
                  end else if (full) begin
                     rsp_data_in.status = swft_pkg::ST_DROPPED;
                  end else begin
                     ctrl.insert            = 1'b1;
                     total_in               = total_ff + 1'b1;
                     rsp_data_in.status     = swft_pkg::ST_INSERTED;
                     rsp_data_in.word_count = swft_pkg::COUNT_BITS'(1);
                     rsp_data_in.position   = 8'(bnd_idx);
                  end
               end
               rsp_data_in.distinct_words = 9'(total_in);
            end
         end
         default: begin
            state_in = swft_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swft_pkg::S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         if (upd_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request and result payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_chan.payload.command;
         key_ff  <= swft_pkg::canon_key({req_chan.payload.key_hi, req_chan.payload.key_lo});
         rank_ff <= req_chan.payload.rank;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // held word count never passes the depth
   `SWFT_ASSERT_ALWAYS(a_total_bound, clock, reset, total_ff <= TW'(TABLE_DEPTH))
   // occupied cells form an unbroken run from the head
   `SWFT_ASSERT_ALWAYS(a_valid_prefix, clock, reset, ((valid_vec >> 1) & ~valid_vec) == '0)
   // the counter agrees with the occupied cells
   `SWFT_ASSERT_ALWAYS(a_total_match, clock, reset, $countones(valid_vec) == int'(total_ff))
   // in the update state, at most one cell marks the insertion point
   `SWFT_ASSERT_ALWAYS(a_bnd_onehot, clock, reset, (state_ff != swft_pkg::S_UPD) || $onehot0(bnd_vec))
   // an insertion grows the table by exactly one
   `SWFT_ASSERT_NEXT(a_insert_grows, clock, reset, ctrl.insert, total_ff == TW'($past(total_ff) + 1'b1))

endmodule

// ===== src/swft_cell.sv =====
// one cell of the sorted chain: a word, its count and its compare flags
module swft_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swft_pkg::cell_ctrl_type              ctrl,
   input  logic [swft_pkg::KEY_BITS-1:0]        req_key,
   input  logic [7:0]                           req_rank,
   input  swft_pkg::cell_view_type              prev,
   output swft_pkg::cell_view_type              view,
   output swft_pkg::cell_flag_type              flag
);

   localparam bit         RANK_REACH = (CELL_INDEX < 256);
   localparam logic [7:0] RANK_MATCH = 8'(CELL_INDEX);

   logic                                valid_ff;
   logic [swft_pkg::KEY_BITS-1:0]       key_ff;
   logic [swft_pkg::COUNT_BITS-1:0]     count_ff;
   logic                                lt_ff;
   logic                                eq_ff;
   logic                                hit_ff;
   logic                                boundary;

   // first cell not below the key: the match or the insertion slot
   assign boundary = !lt_ff && prev.lt;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         if (ctrl.capture) begin
            lt_ff  <= valid_ff && (key_ff < req_key);
            eq_ff  <= valid_ff && (key_ff == req_key);
            hit_ff <= valid_ff && RANK_REACH && (req_rank == RANK_MATCH);
         end
         if (ctrl.insert && !lt_ff) begin
            if (prev.lt) begin
               valid_ff <= 1'b1;
            end else begin
               valid_ff <= prev.valid;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.bump && eq_ff && (count_ff != '1)) begin
         count_ff <= count_ff + 1'b1;
      end else if (ctrl.insert && !lt_ff) begin
         if (prev.lt) begin
            key_ff   <= req_key;
            count_ff <= swft_pkg::COUNT_BITS'(1);
         end else begin
            key_ff   <= prev.key;
            count_ff <= prev.count;
         end
      end
   end

   assign view.valid    = valid_ff;
   assign view.lt       = lt_ff;
   assign view.key      = key_ff;
   assign view.count    = count_ff;
   assign flag.eq       = eq_ff;
   assign flag.hit      = hit_ff;
   assign flag.boundary = boundary;

endmodule

// ===== tb/sorted_word_frequency_table_core_test.sv =====
// self-checking testbench of the sorted word frequency table core
`timescale 1ns / 1ps

module sorted_word_frequency_table_core_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int REPORT_LIMIT   = 20;

   logic clock;
   logic reset;

   swft_chan_if #(.payload_type(swft_pkg::req_payload_type)) req_chan ();
   swft_chan_if #(.payload_type(swft_pkg::rsp_payload_type)) rsp_chan ();

   sorted_word_frequency_table_core #(
      .TABLE_DEPTH(swft_pkg::TABLE_DEPTH)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // predicted table contents, in ascending byte order
   logic [swft_pkg::KEY_BITS-1:0]   held_keys   [swft_pkg::TABLE_DEPTH];
   logic [swft_pkg::COUNT_BITS-1:0] held_counts [swft_pkg::TABLE_DEPTH];
   int                              held_total = 0;

   swft_pkg::rsp_payload_type       pending_replies [$];
   logic [swft_pkg::KEY_BITS-1:0]   word_pool [$];

   int                              mismatch_total = 0;
   int                              stall_left = 0;
   int                              quiet_cycles = 0;
   bit                              idle_on = 1'b1;
   swft_pkg::rsp_payload_type       expected_reply;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // a word ends at its first zero byte, the tail reads as zero
   function automatic logic [swft_pkg::KEY_BITS-1:0] strip_after_nul(
      input logic [swft_pkg::KEY_BITS-1:0] raw
   );
      logic [swft_pkg::KEY_BITS-1:0] res;
      bit                            ended;
      res   = raw;
      ended = 1'b0;
      for (int i = swft_pkg::KEY_BYTES - 1; i >= 0; i--) begin
         if (ended)
            res[8*i +: 8] = 8'h00;
         else if (raw[8*i +: 8] == 8'h00)
            ended = 1'b1;
      end
      return res;
   endfunction

   // expected reply of one word, updates the predicted table
   function automatic swft_pkg::rsp_payload_type predict_table_word(
      input swft_pkg::req_payload_type w
   );
      swft_pkg::rsp_payload_type     r;
      logic [swft_pkg::KEY_BITS-1:0] key;
      int                            slot;
      r = '0;
      if (w.command == swft_pkg::CMD_READ) begin
         r.position = w.rank;
         if (int'(w.rank) < held_total) begin
            r.status                 = swft_pkg::ST_READ_OK;
            {r.word_hi, r.word_lo}   = held_keys[w.rank];
            r.word_count             = held_counts[w.rank];
         end else begin
            r.status = swft_pkg::ST_RANK_EMPTY;
         end
      end else begin
         key  = strip_after_nul({w.key_hi, w.key_lo});
         slot = 0;
         while (slot < held_total && held_keys[slot] < key)
            slot++;
         {r.word_hi, r.word_lo} = key;
         if (slot < held_total && held_keys[slot] == key) begin
            // counts stick at the top
            if (held_counts[slot] != '1)
               held_counts[slot] = held_counts[slot] + 1'b1;
            r.status     = swft_pkg::ST_COUNTED;
            r.word_count = held_counts[slot];
            r.position   = slot[7:0];
         end else if (held_total >= swft_pkg::TABLE_DEPTH) begin
            r.status = swft_pkg::ST_DROPPED;
         end else begin
            for (int j = held_total; j > slot; j--) begin
               held_keys[j]   = held_keys[j-1];
               held_counts[j] = held_counts[j-1];
            end
            held_keys[slot]   = key;
            held_counts[slot] = swft_pkg::COUNT_BITS'(1);
            held_total++;
            r.status     = swft_pkg::ST_INSERTED;
            r.word_count = swft_pkg::COUNT_BITS'(1);
            r.position   = slot[7:0];
         end
      end
      r.distinct_words = held_total[8:0];
      return r;
   endfunction

   function automatic logic [swft_pkg::KEY_BITS-1:0] random_bits();
      logic [127:0] t;
      t = {$urandom, $urandom, $urandom, $urandom};
      return t[swft_pkg::KEY_BITS-1:0];
   endfunction

   // random word of 0 to 15 bytes, sometimes from a tiny alphabet so that
   // words collide and share prefixes, sometimes with junk after the end
   function automatic logic [swft_pkg::KEY_BITS-1:0] random_word(input bit alpha);
      logic [swft_pkg::KEY_BITS-1:0] k;
      int                            len;
      bit                            junk;
      k    = '0;
      len  = $urandom_range(0, swft_pkg::KEY_BYTES);
      junk = ($urandom_range(0, 2) == 0);
      for (int b = 0; b < swft_pkg::KEY_BYTES; b++) begin
         if (b < len)
            k[swft_pkg::KEY_BITS-1-8*b -: 8] = alpha ? 8'(8'h61 + $urandom_range(0, 3))
                                                     : 8'($urandom_range(1, 255));
         else if (b > len && junk)
            k[swft_pkg::KEY_BITS-1-8*b -: 8] = 8'($urandom_range(0, 255));
      end
      return k;
   endfunction

   function automatic swft_pkg::req_payload_type add_item(
      input logic [swft_pkg::KEY_BITS-1:0] key
   );
      swft_pkg::req_payload_type w;
      w.command            = swft_pkg::CMD_ADD;
      {w.key_hi, w.key_lo} = key;
      w.rank               = 8'($urandom_range(0, 255));
      return w;
   endfunction

   function automatic swft_pkg::req_payload_type read_item(input logic [7:0] rank);
      swft_pkg::req_payload_type w;
      w.command            = swft_pkg::CMD_READ;
      {w.key_hi, w.key_lo} = random_bits();
      w.rank               = rank;
      return w;
   endfunction

   // drive one word; valid stays high after acceptance so that back to back
   // words never lower and raise it in the same step
   task automatic send_word(input swft_pkg::req_payload_type w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_replies.push_back(predict_table_word(w));
   endtask

   task automatic check_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatch_total++;
         if (mismatch_total <= REPORT_LIMIT)
            $display("%0t ns: %s expected %0h actual %0h", $time, label, want, got);
      end
   endtask

   // result side: random stall bursts
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left     <= stall_left - 1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left     <= $urandom_range(0, 3);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // compare each accepted reply with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_replies.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_LIMIT)
               $display("%0t ns: reply expected none actual %0h", $time, rsp_chan.payload);
         end else begin
            expected_reply = pending_replies.pop_front();
            check_field("status", 64'(expected_reply.status), 64'(rsp_chan.payload.status));
            check_field("word_hi", expected_reply.word_hi, rsp_chan.payload.word_hi);
            check_field("word_lo", 64'(expected_reply.word_lo), 64'(rsp_chan.payload.word_lo));
            check_field("word_count", 64'(expected_reply.word_count),
                        64'(rsp_chan.payload.word_count));
            check_field("position", 64'(expected_reply.position),
                        64'(rsp_chan.payload.position));
            check_field("distinct_words", 64'(expected_reply.distinct_words),
                        64'(rsp_chan.payload.distinct_words));
         end
      end
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_empty_reads();
      send_word(read_item(8'd0));
      send_word(read_item(8'd255));
      send_word(read_item(8'd1));
   endtask

   task automatic test_special_words();
      logic [swft_pkg::KEY_BITS-1:0] junk;
      junk = random_bits();
      send_word(add_item('0));                                     // empty word
      send_word(add_item({swft_pkg::KEY_BYTES{8'hFF}}));           // largest word
      send_word(add_item({8'h01, 112'h0}));                        // smallest non-empty
      send_word(add_item({8'h41, 8'h00, junk[103:0]}));            // junk after the end
      send_word(add_item({8'h41, 112'h0}));                        // same word, clean
      send_word(add_item({8'h00, ~junk[111:0]}));                  // empty word with junk
      send_word(add_item({8'h41, 8'h42, 8'h43, 96'h0}));
      send_word(add_item({8'h41, 8'h42, 104'h0}));                 // prefix sorts first
      send_word(add_item({8'h41, 8'h42, 8'h00, junk[95:0]}));
      // end of word inside the low half
      send_word(add_item({{8{8'h7F}}, 8'h7F, 8'h7F, 8'h00, junk[31:0]}));
      send_word(add_item({{14{8'h7F}}, 8'h01}));
      send_word(add_item({{swft_pkg::KEY_BYTES-1{8'hFF}}, 8'hFE}));
   endtask

   task automatic test_rank_reads();
      int last;
      last = held_total;
      for (int r = 0; r <= last; r++)
         send_word(read_item(8'(r)));
      send_word(read_item(8'd255));
   endtask

   // mostly repeats and fresh words with random content, some reads
   task automatic run_word_mix(input int count, input bit with_idle);
      int pick;
      for (int i = 0; i < count; i++) begin
         idle_on = with_idle && ((i / 60) % 4 != 3);
         pick    = $urandom_range(0, 99);
         if (pick < 15) begin
            if ($urandom_range(0, 1) == 0)
               send_word(read_item(8'($urandom_range(0, 255))));
            else
               send_word(read_item(8'($urandom_range(0, held_total))));
         end else if (pick < 40 || word_pool.size() == 0) begin
            word_pool.push_back(random_word(1'($urandom_range(0, 1))));
            send_word(add_item(word_pool[$]));
         end else begin
            send_word(add_item(word_pool[$urandom_range(0, word_pool.size() - 1)]));
         end
      end
   endtask

   task automatic test_random_mix();
      run_word_mix(420, 1'b1);
   endtask

   task automatic test_fill_and_drop();
      idle_on = 1'b1;
      while (held_total < swft_pkg::TABLE_DEPTH) begin
         word_pool.push_back(random_word(1'b0));
         send_word(add_item(word_pool[$]));
      end
      // new words now bounce off the full table
      for (int i = 0; i < 6; i++)
         send_word(add_item(random_word(1'b0)));
      send_word(add_item({8'h41, 112'h0}));
      send_word(read_item(8'd0));
      send_word(read_item(8'd255));
      send_word(read_item(8'd128));
   endtask

   task automatic test_full_table_mix();
      run_word_mix(300, 1'b0);
   endtask

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_reads();
      test_special_words();
      test_rank_reads();
      test_random_mix();
      test_fill_and_drop();
      test_full_table_mix();
      // drain outstanding replies, then let the pipeline settle
      req_chan.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/swft_pkg.sv
src/swft_chan_if.sv
src/swft_cell.sv
src/sorted_word_frequency_table_core.sv
tb/sorted_word_frequency_table_core_test.sv
